// File: sv/fbh_pkg.sv
// Shared constants, codes and controller/datapath interface types for the histogram unit.
`timescale 1ns / 1ps

package fbh_pkg;

	localparam int FBH_MAX_BINS   = 64;
	localparam int FBH_COUNT_BITS = 24;

	localparam int SAMPLE_BITS    = 32;
	localparam int STEP_BITS      = 31;
	localparam int BINS_USED_BITS = 7;
	localparam int BIN_INDEX_BITS = 6;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_STEP   = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BINS_USED  = 2'd3;

	localparam logic [SAMPLE_BITS-1:0]    RANGE_LOW_RST  = 32'd0;
	localparam logic [SAMPLE_BITS-1:0]    RANGE_HIGH_RST = 32'd4194304;
	localparam logic [STEP_BITS-1:0]      BIN_STEP_RST   = 31'd65536;
	localparam logic [BINS_USED_BITS-1:0] BINS_USED_RST  = 7'd64;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FLAGS,
		ST_NUM,
		ST_DIV,
		ST_READ,
		ST_WRITE,
		ST_OUT_READ,
		ST_OUT_LOAD,
		ST_OUT_HOLD
	} fbh_state_t;

	typedef struct packed {
		logic load_sample;
		logic calc_flags;
		logic calc_num;
		logic div_step;
		logic bin_read;
		logic bin_write;
		logic out_start;
		logic out_read;
		logic out_load;
		logic out_next;
		logic clr_step;
	} fbh_cmd_t;

	typedef struct packed {
		logic div_done;
		logic clr_last;
		logic eos;
		logic out_last;
	} fbh_status_t;

endpackage

// File: sv/fixed_bin_histogram_unit.sv
// Samples: in_ready is high only in idle, so each sample is captured, flagged, turned
// into a numerator and divided one quotient bit per cycle, then a memory read and write.
// Readout after an end-of-set sample: each bin in use is read, loaded and held until
// out_ready, then a sweep that zeroes every counter before the next sample.
// Reset: configuration registers take their reset values and the same sweep clears the
// counters; in_ready stays low until it ends.
`timescale 1ns / 1ps

module fixed_bin_histogram_unit
	import fbh_pkg::*;
#(
	parameter int MAX_BINS   = FBH_MAX_BINS,
	parameter int COUNT_BITS = FBH_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_BITS-1:0]    sample_value,
	input  logic                      end_of_set,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [BIN_INDEX_BITS-1:0] bin_index,
	output logic [SAMPLE_BITS-1:0]    bin_edge,
	output logic [COUNT_BITS-1:0]     bin_total,
	output logic                      last_bin
);

	fbh_cmd_t    cmd;
	fbh_status_t status;

	fbh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	fbh_dp #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_value (sample_value),
		.end_of_set   (end_of_set),
		.cmd          (cmd),
		.status       (status),
		.bin_index    (bin_index),
		.bin_edge     (bin_edge),
		.bin_total    (bin_total),
		.last_bin     (last_bin)
	);

endmodule

// File: sv/fbh_ctrl.sv
// Controller state machine that sequences binning, readout and clearing.
`timescale 1ns / 1ps

module fbh_ctrl
	import fbh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  fbh_status_t status,
	output fbh_cmd_t    cmd
);

	fbh_state_t state_q;
	fbh_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_FLAGS;
				end
			end
			ST_FLAGS: begin
				cmd.calc_flags = 1'b1;
				state_d        = ST_NUM;
			end
			ST_NUM: begin
				cmd.calc_num = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.bin_read = 1'b1;
				state_d      = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.bin_write = 1'b1;
				if (status.eos) begin
					cmd.out_start = 1'b1;
					state_d       = ST_OUT_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT_READ: begin
				cmd.out_read = 1'b1;
				state_d      = ST_OUT_LOAD;
			end
			ST_OUT_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_OUT_HOLD;
			end
			ST_OUT_HOLD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (status.out_last) begin
						state_d = ST_CLEAR;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = ST_OUT_READ;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// File: sv/fbh_dp.sv
// Datapath: configuration registers, bin search divider, count memory and readout registers.
`timescale 1ns / 1ps

module fbh_dp
	import fbh_pkg::*;
#(
	parameter int MAX_BINS   = FBH_MAX_BINS,
	parameter int COUNT_BITS = FBH_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [SAMPLE_BITS-1:0]    sample_value,
	input  logic                      end_of_set,
	input  fbh_cmd_t                  cmd,
	output fbh_status_t               status,
	output logic [BIN_INDEX_BITS-1:0] bin_index,
	output logic [SAMPLE_BITS-1:0]    bin_edge,
	output logic [COUNT_BITS-1:0]     bin_total,
	output logic                      last_bin
);

	localparam int IDXW = $clog2(MAX_BINS);
	localparam int QW   = IDXW + 1;
	localparam int KW   = $clog2(IDXW + 2);
	localparam int CW   = STEP_BITS + IDXW + 2;
	localparam int NW   = $clog2(MAX_BINS + 1);
	localparam int NCW  = (NW > BINS_USED_BITS) ? NW : BINS_USED_BITS;

	// Configuration registers.
	logic signed [SAMPLE_BITS-1:0] range_low_q;
	logic signed [SAMPLE_BITS-1:0] range_high_q;
	logic [STEP_BITS-1:0]          step_q;
	logic [BINS_USED_BITS-1:0]     bins_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			step_q       <= BIN_STEP_RST;
			bins_used_q  <= BINS_USED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				REG_BIN_STEP:   step_q       <= cfg_data[STEP_BITS-1:0];
				REG_BINS_USED:  bins_used_q  <= cfg_data[BINS_USED_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Number of bins in use, with zero acting as one and large values clipped.
	logic [NCW-1:0]  bu_ext;
	logic [NCW-1:0]  n_act;
	logic [IDXW-1:0] n_last;

	always_comb begin
		bu_ext = NCW'(bins_used_q);
		if (bu_ext == '0) begin
			n_act = NCW'(1);
		end else if (bu_ext > NCW'(MAX_BINS)) begin
			n_act = NCW'(MAX_BINS);
		end else begin
			n_act = bu_ext;
		end
		n_last = IDXW'(n_act - NCW'(1));
	end

	// Sample capture, range flags and the saturating ceiling divider.
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          eos_q;
	logic                          below_q;
	logic                          above_q;
	logic [SAMPLE_BITS-1:0]        diff_q;
	logic                          zdiff_q;
	logic [CW-1:0]                 rem_q;
	logic [QW-1:0]                 quot_q;
	logic                          sat_q;
	logic [KW-1:0]                 k_q;
	logic [CW-1:0]                 shifted;
	logic                          rem_ge;

	assign shifted = CW'(step_q) << k_q;
	assign rem_ge  = (rem_q >= shifted);

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= sample_value;
			eos_q    <= end_of_set;
		end
		if (cmd.calc_flags) begin
			below_q <= (sample_q < range_low_q);
			above_q <= (sample_q > range_high_q);
			diff_q  <= SAMPLE_BITS'(sample_q - range_low_q);
		end
		if (cmd.calc_num) begin
			// Numerator diff + step - 1 turns the floor division into a ceiling.
			rem_q   <= CW'(diff_q) + CW'(step_q) - CW'(1);
			zdiff_q <= (diff_q == '0);
			quot_q  <= '0;
			sat_q   <= 1'b0;
			k_q     <= KW'(IDXW + 1);
		end
		if (cmd.div_step) begin
			// The top position only detects a quotient beyond every bin.
			if (k_q == KW'(IDXW + 1)) begin
				if (rem_ge) begin
					sat_q <= 1'b1;
				end
			end else if (rem_ge) begin
				rem_q  <= rem_q - shifted;
				quot_q <= quot_q | (QW'(1) << k_q);
			end
			k_q <= k_q - KW'(1);
		end
	end

	// Bin selection from the flags and quotient.
	logic [IDXW-1:0] bin_sel;

	always_comb begin
		priority if (below_q) begin
			bin_sel = '0;
		end else if (above_q) begin
			bin_sel = n_last;
		end else if (step_q == '0) begin
			bin_sel = zdiff_q ? '0 : n_last;
		end else if (sat_q || (quot_q > QW'(n_last))) begin
			bin_sel = n_last;
		end else begin
			bin_sel = IDXW'(quot_q);
		end
	end

	// Count memory with registered read data.
	logic [COUNT_BITS-1:0] bin_mem [MAX_BINS];
	logic [COUNT_BITS-1:0] rd_q;
	logic [IDXW-1:0]       bin_q;
	logic [IDXW-1:0]       clr_idx_q;
	logic [IDXW-1:0]       out_idx_q;
	logic                  mem_we;
	logic [IDXW-1:0]       mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;
	logic [IDXW-1:0]       mem_ra;
	logic [COUNT_BITS-1:0] cnt_inc;

	assign cnt_inc = (rd_q == '1) ? rd_q : (rd_q + COUNT_BITS'(1));
	assign mem_we  = cmd.clr_step | cmd.bin_write;
	assign mem_wa  = cmd.clr_step ? clr_idx_q : bin_q;
	assign mem_wd  = cmd.clr_step ? '0 : cnt_inc;
	assign mem_ra  = cmd.out_read ? out_idx_q : bin_sel;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[mem_wa] <= mem_wd;
		end
		if (cmd.bin_read || cmd.out_read) begin
			rd_q <= bin_mem[mem_ra];
		end
		if (cmd.bin_read) begin
			bin_q <= bin_sel;
		end
	end

	// The clear pointer wraps to zero after the last entry, ready for the next sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			if (clr_idx_q == IDXW'(MAX_BINS - 1)) begin
				clr_idx_q <= '0;
			end else begin
				clr_idx_q <= clr_idx_q + IDXW'(1);
			end
		end
	end

	// Readout walk: bin pointer, running edge and the output register.
	logic [SAMPLE_BITS-1:0] edge_acc_q;
	logic [IDXW-1:0]        out_bin_q;
	logic [SAMPLE_BITS-1:0] out_edge_q;
	logic [COUNT_BITS-1:0]  out_total_q;
	logic                   out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.out_start) begin
			out_idx_q  <= '0;
			edge_acc_q <= range_low_q;
		end else if (cmd.out_next) begin
			out_idx_q  <= out_idx_q + IDXW'(1);
			edge_acc_q <= edge_acc_q + SAMPLE_BITS'(step_q);
		end
		if (cmd.out_load) begin
			out_bin_q   <= out_idx_q;
			out_edge_q  <= edge_acc_q;
			out_total_q <= rd_q;
			out_last_q  <= (out_idx_q == n_last);
		end
	end

	assign bin_index = BIN_INDEX_BITS'(out_bin_q);
	assign bin_edge  = out_edge_q;
	assign bin_total = out_total_q;
	assign last_bin  = out_last_q;

	assign status.div_done = (k_q == '0);
	assign status.clr_last = (clr_idx_q == IDXW'(MAX_BINS - 1));
	assign status.eos      = eos_q;
	assign status.out_last = out_last_q;

endmodule
